[src/mco_pkg.sv]
// Shared constants, types and helpers for the matrix chain order block.
`default_nettype none
package mco_pkg;

    localparam int DEF_MAX_MATRICES = 16;
    localparam int DEF_DIM_BITS     = 16;

    localparam int COST_W = 52;
    localparam int WIDE_W = 64;
    localparam int IDX_W  = 5;
    localparam int PAR_W  = 4;

    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};
    localparam logic [PAR_W-1:0]  PAR_MAX  = {PAR_W{1'b1}};

    // Steps of the shared cost unit
    localparam logic [1:0] CU_MUL_A  = 2'd0;
    localparam logic [1:0] CU_MUL_LO = 2'd1;
    localparam logic [1:0] CU_MUL_HI = 2'd2;

    typedef struct packed {
        logic       en;
        logic [1:0] step;
    } mco_cu_ctrl_t;

    // Clamp a wide sum to the cost range
    function automatic logic [COST_W-1:0] sat_cost(input logic [WIDE_W-1:0] v);
        if (v > WIDE_W'(COST_MAX)) begin
            sat_cost = COST_MAX;
        end else begin
            sat_cost = v[COST_W-1:0];
        end
    endfunction

endpackage
`default_nettype wire

[src/mco_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mco_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

[src/mco_cost_unit.sv]
// Shared multiply and saturating add unit for one split candidate.
`default_nettype none
module mco_cost_unit import mco_pkg::*; #(
    parameter int DIM_BITS = DEF_DIM_BITS
) (
    input  wire logic                aclk,
    input  wire mco_cu_ctrl_t        ctrl,
    input  wire logic [DIM_BITS-1:0] row_i,
    input  wire logic [DIM_BITS-1:0] col_j,
    input  wire logic [DIM_BITS-1:0] col_k,
    input  wire logic [COST_W-1:0]   cost_a,
    input  wire logic [COST_W-1:0]   cost_b,
    input  wire logic                a_zero,
    input  wire logic                b_zero,
    output logic      [COST_W-1:0]   total
);

    localparam int PW = 2 * DIM_BITS;

    logic [PW-1:0]       a_reg, a_next;
    logic [PW-1:0]       plo_reg, plo_next;
    logic [COST_W-1:0]   s_reg, s_next;
    logic [COST_W-1:0]   prod_reg, prod_next;
    logic [DIM_BITS-1:0] op_x, op_y;
    logic [PW-1:0]       mul;
    logic [COST_W-1:0]   ca_eff, cb_eff;

    // Pick multiplier operands for the current step
    always_comb begin
        unique case (ctrl.step)
            CU_MUL_LO: begin
                op_x = a_reg[DIM_BITS-1:0];
                op_y = col_j;
            end
            CU_MUL_HI: begin
                op_x = a_reg[PW-1:DIM_BITS];
                op_y = col_j;
            end
            default: begin
                op_x = row_i;
                op_y = col_k;
            end
        endcase
    end

    assign mul    = PW'(op_x) * PW'(op_y);
    assign ca_eff = a_zero ? '0 : cost_a;
    assign cb_eff = b_zero ? '0 : cost_b;

    // Advance the step registers
    always_comb begin
        a_next    = a_reg;
        plo_next  = plo_reg;
        s_next    = s_reg;
        prod_next = prod_reg;
        if (ctrl.en) begin
            unique case (ctrl.step)
                CU_MUL_A: begin
                    a_next = mul;
                    s_next = sat_cost(WIDE_W'(ca_eff) + WIDE_W'(cb_eff));
                end
                CU_MUL_LO: begin
                    plo_next = mul;
                end
                CU_MUL_HI: begin
                    prod_next = sat_cost(WIDE_W'(plo_reg) + (WIDE_W'(mul) << DIM_BITS));
                end
                default: begin
                    a_next = a_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        a_reg    <= a_next;
        plo_reg  <= plo_next;
        s_reg    <= s_next;
        prod_reg <= prod_next;
    end

    assign total = sat_cost(WIDE_W'(s_reg) + WIDE_W'(prod_reg));

endmodule
`default_nettype wire

[src/matrix_chain_order.sv]
// Matrix chain order: load a chain, fill the interval cost table, count parentheses.
//
//  channel | ports                                   | direction
//  s_      | s_rows s_cols s_last_matrix             | in,  valid/ready
//  m_      | m_matrix_index m_open_parens            | out, valid/ready
//          | m_close_parens m_min_cost m_overflow    |
//          | m_last_result                           |
//
// Loading accepts one matrix per cycle while s_ready is high. On the last matrix
// the sequencer fills the table per interval: read the end dimensions, run each
// split candidate in turn through the shared multiplier, write the best. A split
// walk over the tree follows, then results leave one per cycle while m_ready is high.
// Reset is synchronous, active low. s_ready is low from the last matrix until the
// final result transfers; m_ready low holds the result register.
`default_nettype none
module matrix_chain_order import mco_pkg::*; #(
    parameter int MAX_MATRICES = DEF_MAX_MATRICES,
    parameter int DIM_BITS     = DEF_DIM_BITS
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [15:0]       s_rows,
    input  wire logic [15:0]       s_cols,
    input  wire logic              s_last_matrix,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [IDX_W-1:0]       m_matrix_index,
    output logic [PAR_W-1:0]       m_open_parens,
    output logic [PAR_W-1:0]       m_close_parens,
    output logic [COST_W-1:0]      m_min_cost,
    output logic                   m_overflow,
    output logic                   m_last_result
);

    localparam int IW  = $clog2(MAX_MATRICES);
    localparam int CW  = $clog2(MAX_MATRICES + 1);
    localparam int TD  = MAX_MATRICES * MAX_MATRICES;
    localparam int AW  = $clog2(TD);
    localparam int SD  = 2 * MAX_MATRICES + 2;
    localparam int SAW = $clog2(SD);
    localparam int SW  = $clog2(SD + 1);
    localparam int EW  = 2 * IW;

    localparam logic [4:0] ST_LOAD  = 5'd0;
    localparam logic [4:0] ST_IVL0  = 5'd1;
    localparam logic [4:0] ST_IVL1  = 5'd2;
    localparam logic [4:0] ST_K0    = 5'd3;
    localparam logic [4:0] ST_K1    = 5'd4;
    localparam logic [4:0] ST_K2    = 5'd5;
    localparam logic [4:0] ST_K3    = 5'd6;
    localparam logic [4:0] ST_K4    = 5'd7;
    localparam logic [4:0] ST_WR    = 5'd8;
    localparam logic [4:0] ST_WINIT = 5'd9;
    localparam logic [4:0] ST_POP   = 5'd10;
    localparam logic [4:0] ST_POPD  = 5'd11;
    localparam logic [4:0] ST_SPL   = 5'd12;
    localparam logic [4:0] ST_PUSH2 = 5'd13;
    localparam logic [4:0] ST_TOT0  = 5'd14;
    localparam logic [4:0] ST_TOT1  = 5'd15;
    localparam logic [4:0] ST_OUT   = 5'd16;

    function automatic logic [AW-1:0] taddr(input logic [IW-1:0] r, input logic [IW-1:0] c);
        taddr = AW'(r) * AW'(MAX_MATRICES) + AW'(c);
    endfunction

    logic [4:0]          state_reg, state_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic                drop_reg, drop_next;
    logic [CW-1:0]       ln_reg, ln_next;
    logic [CW-1:0]       i_reg, i_next;
    logic [CW-1:0]       k_reg, k_next;
    logic [DIM_BITS-1:0] row_i_reg, row_i_next;
    logic [DIM_BITS-1:0] col_j_reg, col_j_next;
    logic [COST_W-1:0]   best_reg, best_next;
    logic [IW-1:0]       bk_reg, bk_next;
    logic [SW-1:0]       sp_reg, sp_next;
    logic [IW-1:0]       x_reg, x_next;
    logic [IW-1:0]       y_reg, y_next;
    logic [COST_W-1:0]   total_reg, total_next;
    logic [CW-1:0]       m_reg, m_next;
    logic                mv_reg, mv_next;
    logic [IDX_W-1:0]    oidx_reg, oidx_next;
    logic [PAR_W-1:0]    oopen_reg, oopen_next;
    logic [PAR_W-1:0]    oclose_reg, oclose_next;
    logic                olast_reg, olast_next;
    logic [PAR_W-1:0]    open_reg [MAX_MATRICES];
    logic [PAR_W-1:0]    open_next [MAX_MATRICES];
    logic [PAR_W-1:0]    close_reg [MAX_MATRICES];
    logic [PAR_W-1:0]    close_next [MAX_MATRICES];

    logic                accept;
    logic [CW:0]         j_w;
    logic [CW:0]         k1_w;
    logic [IW-1:0]       i_idx, j_idx, k_idx, k1_idx;
    logic [IW-1:0]       pop_x, pop_y;
    logic                out_load;
    logic [CW-1:0]       out_sel;
    logic [CW-1:0]       n_new;

    // RAM ports
    logic                dim_we;
    logic [IW-1:0]       row_raddr, col_raddr;
    logic [DIM_BITS-1:0] row_rdata, col_rdata;
    logic                cost_we;
    logic [AW-1:0]       cost_waddr, ca_raddr, cb_raddr;
    logic [COST_W-1:0]   ca_rdata, cb_rdata;
    logic [AW-1:0]       split_raddr;
    logic [IW-1:0]       split_rdata;
    logic                stk_we;
    logic [SAW-1:0]      stk_waddr, stk_raddr;
    logic [EW-1:0]       stk_wdata, stk_rdata;
    mco_cu_ctrl_t        cu_ctrl;
    logic [COST_W-1:0]   cu_total;

    assign accept = s_valid && s_ready;
    assign s_ready = (state_reg == ST_LOAD);
    assign j_w    = (CW+1)'(i_reg) + (CW+1)'(ln_reg);
    assign k1_w   = (CW+1)'(k_reg) + (CW+1)'(1);
    assign i_idx  = i_reg[IW-1:0];
    assign j_idx  = j_w[IW-1:0];
    assign k_idx  = k_reg[IW-1:0];
    assign k1_idx = k1_w[IW-1:0];
    assign pop_x  = stk_rdata[EW-1:IW];
    assign pop_y  = stk_rdata[IW-1:0];
    assign n_new  = (cnt_reg < CW'(MAX_MATRICES)) ? cnt_reg + CW'(1) : cnt_reg;

    // Stores
    mco_ram #(.WIDTH(DIM_BITS), .DEPTH(MAX_MATRICES)) u_rows (
        .aclk(aclk), .we(dim_we), .waddr(cnt_reg[IW-1:0]), .wdata(DIM_BITS'(s_rows)),
        .raddr(row_raddr), .rdata(row_rdata)
    );
    mco_ram #(.WIDTH(DIM_BITS), .DEPTH(MAX_MATRICES)) u_cols (
        .aclk(aclk), .we(dim_we), .waddr(cnt_reg[IW-1:0]), .wdata(DIM_BITS'(s_cols)),
        .raddr(col_raddr), .rdata(col_rdata)
    );
    mco_ram #(.WIDTH(COST_W), .DEPTH(TD)) u_cost_a (
        .aclk(aclk), .we(cost_we), .waddr(cost_waddr), .wdata(best_reg),
        .raddr(ca_raddr), .rdata(ca_rdata)
    );
    mco_ram #(.WIDTH(COST_W), .DEPTH(TD)) u_cost_b (
        .aclk(aclk), .we(cost_we), .waddr(cost_waddr), .wdata(best_reg),
        .raddr(cb_raddr), .rdata(cb_rdata)
    );
    mco_ram #(.WIDTH(IW), .DEPTH(TD)) u_split (
        .aclk(aclk), .we(cost_we), .waddr(cost_waddr), .wdata(bk_reg),
        .raddr(split_raddr), .rdata(split_rdata)
    );
    mco_ram #(.WIDTH(EW), .DEPTH(SD)) u_stack (
        .aclk(aclk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
        .raddr(stk_raddr), .rdata(stk_rdata)
    );

    mco_cost_unit #(.DIM_BITS(DIM_BITS)) u_cost_unit (
        .aclk(aclk), .ctrl(cu_ctrl), .row_i(row_i_reg), .col_j(col_j_reg),
        .col_k(col_rdata), .cost_a(ca_rdata), .cost_b(cb_rdata),
        .a_zero(i_reg == k_reg), .b_zero(k1_w == j_w), .total(cu_total)
    );

    // Sequencer
    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        drop_next   = drop_reg;
        ln_next     = ln_reg;
        i_next      = i_reg;
        k_next      = k_reg;
        row_i_next  = row_i_reg;
        col_j_next  = col_j_reg;
        best_next   = best_reg;
        bk_next     = bk_reg;
        sp_next     = sp_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        total_next  = total_reg;
        m_next      = m_reg;
        mv_next     = mv_reg;
        open_next   = open_reg;
        close_next  = close_reg;
        out_load    = 1'b0;
        out_sel     = m_reg;
        dim_we      = 1'b0;
        row_raddr   = i_idx;
        col_raddr   = j_idx;
        cost_we     = 1'b0;
        cost_waddr  = taddr(i_idx, j_idx);
        ca_raddr    = taddr(i_idx, k_idx);
        cb_raddr    = taddr(k1_idx, j_idx);
        split_raddr = taddr(pop_x, pop_y);
        stk_we      = 1'b0;
        stk_waddr   = sp_reg[SAW-1:0];
        stk_wdata   = {x_reg, k_idx};
        stk_raddr   = SAW'(sp_reg - SW'(1));
        cu_ctrl     = '{en: 1'b0, step: CU_MUL_A};

        unique case (state_reg)
            ST_LOAD: begin
                if (accept) begin
                    if (cnt_reg < CW'(MAX_MATRICES)) begin
                        dim_we   = 1'b1;
                        cnt_next = cnt_reg + CW'(1);
                    end else begin
                        drop_next = 1'b1;
                    end
                    if (s_last_matrix) begin
                        for (int e = 0; e < MAX_MATRICES; e++) begin
                            open_next[e]  = '0;
                            close_next[e] = '0;
                        end
                        ln_next = CW'(1);
                        i_next  = '0;
                        state_next = (n_new == CW'(1)) ? ST_WINIT : ST_IVL0;
                    end
                end
            end
            ST_IVL0: begin
                state_next = ST_IVL1;
            end
            ST_IVL1: begin
                row_i_next = row_rdata;
                col_j_next = col_rdata;
                k_next     = i_reg;
                state_next = ST_K0;
            end
            ST_K0: begin
                col_raddr  = k_idx;
                state_next = ST_K1;
            end
            ST_K1: begin
                cu_ctrl    = '{en: 1'b1, step: CU_MUL_A};
                state_next = ST_K2;
            end
            ST_K2: begin
                cu_ctrl    = '{en: 1'b1, step: CU_MUL_LO};
                state_next = ST_K3;
            end
            ST_K3: begin
                cu_ctrl    = '{en: 1'b1, step: CU_MUL_HI};
                state_next = ST_K4;
            end
            ST_K4: begin
                // keep the smallest split on a tie
                if (k_reg == i_reg || cu_total < best_reg) begin
                    best_next = cu_total;
                    bk_next   = k_idx;
                end
                if (k1_w == j_w) begin
                    state_next = ST_WR;
                end else begin
                    k_next     = k_reg + CW'(1);
                    state_next = ST_K0;
                end
            end
            ST_WR: begin
                cost_we = 1'b1;
                if ((CW+2)'(j_w) + (CW+2)'(1) < (CW+2)'(cnt_reg)) begin
                    i_next     = i_reg + CW'(1);
                    state_next = ST_IVL0;
                end else if ((CW+1)'(ln_reg) + (CW+1)'(1) < (CW+1)'(cnt_reg)) begin
                    ln_next    = ln_reg + CW'(1);
                    i_next     = '0;
                    state_next = ST_IVL0;
                end else begin
                    state_next = ST_WINIT;
                end
            end
            ST_WINIT: begin
                stk_we     = 1'b1;
                stk_waddr  = '0;
                stk_wdata  = {IW'(0), IW'(cnt_reg - CW'(1))};
                sp_next    = SW'(1);
                state_next = ST_POP;
            end
            ST_POP: begin
                if (sp_reg == '0) begin
                    state_next = ST_TOT0;
                end else begin
                    sp_next    = sp_reg - SW'(1);
                    state_next = ST_POPD;
                end
            end
            ST_POPD: begin
                x_next = pop_x;
                y_next = pop_y;
                if (pop_x >= pop_y) begin
                    state_next = ST_POP;
                end else begin
                    for (int e = 0; e < MAX_MATRICES; e++) begin
                        if (IW'(e) == pop_x && open_reg[e] != PAR_MAX) begin
                            open_next[e] = open_reg[e] + PAR_W'(1);
                        end
                        if (IW'(e) == pop_y && close_reg[e] != PAR_MAX) begin
                            close_next[e] = close_reg[e] + PAR_W'(1);
                        end
                    end
                    if ((IW+1)'(pop_y) == (IW+1)'(pop_x) + (IW+1)'(1)) begin
                        state_next = ST_POP;
                    end else begin
                        state_next = ST_SPL;
                    end
                end
            end
            ST_SPL: begin
                k_next     = CW'(split_rdata);
                stk_we     = 1'b1;
                stk_wdata  = {split_rdata + IW'(1), y_reg};
                sp_next    = sp_reg + SW'(1);
                state_next = ST_PUSH2;
            end
            ST_PUSH2: begin
                stk_we     = 1'b1;
                sp_next    = sp_reg + SW'(1);
                state_next = ST_POP;
            end
            ST_TOT0: begin
                ca_raddr   = taddr('0, IW'(cnt_reg - CW'(1)));
                state_next = ST_TOT1;
            end
            ST_TOT1: begin
                total_next = (cnt_reg == CW'(1)) ? '0 : ca_rdata;
                m_next     = '0;
                out_sel    = '0;
                out_load   = 1'b1;
                mv_next    = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (mv_reg && m_ready) begin
                    if (m_reg + CW'(1) == cnt_reg) begin
                        mv_next    = 1'b0;
                        cnt_next   = '0;
                        drop_next  = 1'b0;
                        state_next = ST_LOAD;
                    end else begin
                        m_next   = m_reg + CW'(1);
                        out_sel  = m_reg + CW'(1);
                        out_load = 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Result register fields
    always_comb begin
        oidx_next   = oidx_reg;
        oopen_next  = oopen_reg;
        oclose_next = oclose_reg;
        olast_next  = olast_reg;
        if (out_load) begin
            oidx_next   = IDX_W'(out_sel) + IDX_W'(1);
            oopen_next  = open_reg[out_sel[IW-1:0]];
            oclose_next = close_reg[out_sel[IW-1:0]];
            olast_next  = ((CW+1)'(out_sel) + (CW+1)'(1) == (CW+1)'(cnt_reg));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            cnt_reg   <= '0;
            drop_reg  <= 1'b0;
            sp_reg    <= '0;
            m_reg     <= '0;
            mv_reg    <= 1'b0;
            for (int e = 0; e < MAX_MATRICES; e++) begin
                open_reg[e]  <= '0;
                close_reg[e] <= '0;
            end
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            drop_reg  <= drop_next;
            sp_reg    <= sp_next;
            m_reg     <= m_next;
            mv_reg    <= mv_next;
            open_reg  <= open_next;
            close_reg <= close_next;
        end
    end

    // Payload registers hold without reset
    always_ff @(posedge aclk) begin
        ln_reg     <= ln_next;
        i_reg      <= i_next;
        k_reg      <= k_next;
        row_i_reg  <= row_i_next;
        col_j_reg  <= col_j_next;
        best_reg   <= best_next;
        bk_reg     <= bk_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        total_reg  <= total_next;
        oidx_reg   <= oidx_next;
        oopen_reg  <= oopen_next;
        oclose_reg <= oclose_next;
        olast_reg  <= olast_next;
    end

    assign m_valid        = mv_reg;
    assign m_matrix_index = oidx_reg;
    assign m_open_parens  = oopen_reg;
    assign m_close_parens = oclose_reg;
    assign m_min_cost     = total_reg;
    assign m_overflow     = drop_reg;
    assign m_last_result  = olast_reg;

`ifndef SYNTH
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(MAX_MATRICES))
        else $error("chain length above capacity");

    a_sp_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        sp_reg <= SW'(SD))
        else $error("split walk stack overrun");

    a_out_in_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        mv_reg |-> (m_reg < cnt_reg))
        else $error("result index beyond chain");

    a_busy_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_last_matrix) |=> !s_ready)
        else $error("input taken while chain is evaluated");

    a_split_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_K4) |-> ((k_reg >= i_reg) && ((CW+1)'(k_reg) < j_w)))
        else $error("split candidate outside interval");
`endif

endmodule
`default_nettype wire

[bench/testbench.sv]
// Self-checking bench for the matrix chain order block: queued driver, monitor, predictor.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    import mco_pkg::*;

    localparam int NMAX       = DEF_MAX_MATRICES;
    localparam int IDLE_LIMIT = 40000;
    localparam int DRAIN      = 200;

    typedef struct packed {
        logic [15:0] rows;
        logic [15:0] cols;
        logic        last;
    } mat_item_t;

    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic [PAR_W-1:0]  opens;
        logic [PAR_W-1:0]  closes;
        logic [COST_W-1:0] cost;
        logic              ovf;
        logic              last;
    } paren_res_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [15:0] s_rows = '0;
    logic [15:0] s_cols = '0;
    logic s_last_matrix = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [IDX_W-1:0]  m_matrix_index;
    logic [PAR_W-1:0]  m_open_parens;
    logic [PAR_W-1:0]  m_close_parens;
    logic [COST_W-1:0] m_min_cost;
    logic m_overflow;
    logic m_last_result;

    mat_item_t  pending_q[$];
    paren_res_t paren_q[$];
    int mismatches = 0;
    int results_seen = 0;
    int idle_cycles = 0;

    // predictor copy of the chain being loaded
    logic [15:0] row_store[NMAX];
    logic [15:0] col_store[NMAX];
    int          stored_len = 0;
    logic        drop_seen = 1'b0;

    matrix_chain_order i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_rows(s_rows), .s_cols(s_cols), .s_last_matrix(s_last_matrix),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_matrix_index(m_matrix_index), .m_open_parens(m_open_parens),
        .m_close_parens(m_close_parens), .m_min_cost(m_min_cost),
        .m_overflow(m_overflow), .m_last_result(m_last_result)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [63:0] clamp_cost(input logic [63:0] v);
        return (v > 64'(COST_MAX)) ? 64'(COST_MAX) : v;
    endfunction

    // Store one matrix; on the last one solve the chain and queue its results
    task automatic solve_chain(input mat_item_t it);
        logic [63:0] cst[NMAX][NMAX];
        int          spl[NMAX][NMAX];
        logic [3:0]  opn[NMAX];
        logic [3:0]  cls[NMAX];
        int          lo_s[2*NMAX+2];
        int          hi_s[2*NMAX+2];
        int          sp, n, j, x, y, k;
        logic [63:0] best, prod, t;
        paren_res_t  r;
        if (stored_len < NMAX) begin
            row_store[stored_len] = it.rows;
            col_store[stored_len] = it.cols;
            stored_len++;
        end else begin
            drop_seen = 1'b1;
        end
        if (!it.last) return;
        n = stored_len;
        for (int a = 0; a < NMAX; a++) begin
            opn[a] = '0;
            cls[a] = '0;
            for (int b = 0; b < NMAX; b++) begin
                cst[a][b] = '0;
                spl[a][b] = 0;
            end
        end
        // interval sweep, smallest split wins a tie
        for (int len = 1; len < n; len++) begin
            for (int i = 0; i + len < n; i++) begin
                j = i + len;
                best = 64'h7fffffffffffffff;
                spl[i][j] = i;
                for (int kk = i; kk < j; kk++) begin
                    prod = clamp_cost(64'(row_store[i]) * 64'(col_store[kk])
                                      * 64'(col_store[j]));
                    t = clamp_cost(clamp_cost(cst[i][kk] + cst[kk+1][j]) + prod);
                    if (t < best) begin
                        best = t;
                        spl[i][j] = kk;
                    end
                end
                cst[i][j] = best;
            end
        end
        // walk the split tree
        lo_s[0] = 0;
        hi_s[0] = n - 1;
        sp = 1;
        while (sp > 0) begin
            sp--;
            x = lo_s[sp];
            y = hi_s[sp];
            if (x < y) begin
                if (opn[x] != 4'hf) opn[x]++;
                if (cls[y] != 4'hf) cls[y]++;
                if (y != x + 1) begin
                    k = spl[x][y];
                    lo_s[sp] = k + 1; hi_s[sp] = y; sp++;
                    lo_s[sp] = x; hi_s[sp] = k; sp++;
                end
            end
        end
        for (int m = 0; m < n; m++) begin
            r.idx    = IDX_W'(m + 1);
            r.opens  = opn[m];
            r.closes = cls[m];
            r.cost   = cst[0][n-1][COST_W-1:0];
            r.ovf    = drop_seen;
            r.last   = (m + 1 == n);
            paren_q.push_back(r);
        end
        stored_len = 0;
        drop_seen = 1'b0;
    endtask

    function automatic logic [15:0] pick_dim();
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'hffff;
            2: return 16'($urandom);
            default: return 16'($urandom_range(1, 40));
        endcase
    endfunction

    task automatic queue_chain(input int len, input bit consistent);
        mat_item_t it;
        logic [15:0] prev_cols;
        prev_cols = pick_dim();
        for (int i = 0; i < len; i++) begin
            it.rows = consistent ? prev_cols : pick_dim();
            it.cols = pick_dim();
            it.last = (i == len - 1);
            prev_cols = it.cols;
            pending_q.push_back(it);
        end
    endtask

    // Driver: bursts of transfers separated by random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                solve_chain('{s_rows, s_cols, s_last_matrix});
            end
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_valid <= 1'b0;
            end else if (pending_q.size() > 0) begin
                mat_item_t nx;
                nx = pending_q.pop_front();
                s_rows <= nx.rows;
                s_cols <= nx.cols;
                s_last_matrix <= nx.last;
                s_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver stall pattern, with one long hold-off
    int mode_left = 0;
    int rx_mode = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                mode_left <= $urandom_range(16, 96);
                rx_mode <= $urandom_range(0, 2);
            end else begin
                mode_left <= mode_left - 1;
            end
            if (!hold_done && results_seen >= 30) begin
                hold_done <= 1'b1;
                hold_left <= 500;
                m_ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_ready <= 1'b0;
            end else begin
                case (rx_mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= $urandom_range(0, 1);
                    default: m_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Monitor: compare each result transfer with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
                $display("== FAIL ==");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (m_valid && m_ready) begin
                paren_res_t got, want;
                got = '{m_matrix_index, m_open_parens, m_close_parens,
                        m_min_cost, m_overflow, m_last_result};
                results_seen <= results_seen + 1;
                if (paren_q.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("unexpected result idx=%0d", m_matrix_index);
                end else begin
                    want = paren_q.pop_front();
                    if (got !== want) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("mismatch exp idx=%0d o=%0d c=%0d cost=%0d ov=%0b l=%0b | act idx=%0d o=%0d c=%0d cost=%0d ov=%0b l=%0b",
                                     want.idx, want.opens, want.closes, want.cost,
                                     want.ovf, want.last, got.idx, got.opens,
                                     got.closes, got.cost, got.ovf, got.last);
                    end
                end
            end
        end
    end

    // Stimulus and end of run
    initial begin
        mat_item_t it;
        int total;
        // single matrix, zero dims
        pending_q.push_back('{16'd0, 16'd0, 1'b1});
        // two matrices at full scale
        pending_q.push_back('{16'hffff, 16'hffff, 1'b0});
        pending_q.push_back('{16'hffff, 16'hffff, 1'b1});
        // all-zero chain: every split ties
        for (int i = 0; i < 3; i++) pending_q.push_back('{16'd0, 16'd0, i == 2});
        // chain past capacity, last mark on a dropped item
        for (int i = 0; i < 17; i++) begin
            it.rows = (i % 2) ? 16'hffff : 16'h5a5a;
            it.cols = (i % 3) ? 16'ha5a5 : 16'hffff;
            it.last = (i == 16);
            pending_q.push_back(it);
        end
        total = pending_q.size();
        while (total < 220) begin
            int len, pick;
            pick = $urandom_range(0, 19);
            if (pick == 0) len = 16;
            else if (pick == 1) len = $urandom_range(17, 19);
            else len = $urandom_range(1, 8);
            queue_chain(len, $urandom_range(0, 3) != 0);
            total += len;
        end
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        wait (pending_q.size() == 0 && !s_valid && paren_q.size() == 0);
        repeat (DRAIN) @(posedge aclk);
        if (mismatches == 0 && paren_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
`default_nettype wire

[sim.f]
src/mco_pkg.sv
src/mco_ram.sv
src/mco_cost_unit.sv
src/matrix_chain_order.sv
bench/testbench.sv
